// ===== src/mcfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame sync package
// Shared types, constants and helpers of the multi-camera frame sync block.
// ----------------------------------------------------------------------------
package mcfs_pkg;

  // Number of slots in the grouping ring.
  localparam int SLOT_COUNT = 3;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam int STAMP_W = 63;
  localparam int GID_W   = 32;
  localparam int CNT_W   = 4;
  localparam int TOL_W   = 32;
  localparam int CFG_W   = 32;

  typedef logic [SLOT_W-1:0]  slot_idx_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [GID_W-1:0]   gid_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  localparam slot_idx_t SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);
  localparam cnt_t      COUNT_MAX = 4'd15;

  // Item kinds.
  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_ORDER    = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_NUM_CAMERAS = 1'b0;
  localparam logic CFG_TIME_TOL    = 1'b1;

  localparam cnt_t                 NUM_CAMERAS_RST = 4'd2;
  localparam logic [TOL_W-1:0]     TIME_TOL_RST    = 32'd5000000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch the item and start the search at the write pointer
    logic probe;   // test the slot under the search index
    logic last;    // this probe is the final one of the sweep
    logic commit;  // apply the update and register the result
  } mcfs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic match;   // slot under the search index matches the item
    logic skip;    // item kind needs no search
  } mcfs_sts_t;

  // Ring successor of a slot index.
  function automatic slot_idx_t next_slot(input slot_idx_t idx);
    next_slot = (idx == SLOT_LAST) ? '0 : slot_idx_t'(idx + 1'b1);
  endfunction

endpackage

// ===== src/mcfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Frame sync controller
// Sequences acceptance, the slot-by-slot search and the final update.
// ----------------------------------------------------------------------------
module mcfs_ctrl import mcfs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  mcfs_sts_t sts_i,
  output mcfs_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state_q, state_d;
  slot_idx_t  step_q, step_d;
  logic       last_step;

  assign last_step = (step_q == SLOT_LAST);
  assign busy      = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.probe = ~sts_i.skip;
        cmd_o.last  = last_step;
        if (sts_i.skip || sts_i.match || last_step) begin
          state_d = ST_COMMIT;
        end else begin
          step_d = slot_idx_t'(step_q + 1'b1);
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

// ===== src/mcfs_dp.sv =====
// ----------------------------------------------------------------------------
// Frame sync datapath
// Slot ring, configuration registers, match logic, updates and result registers.
// ----------------------------------------------------------------------------
module mcfs_dp import mcfs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic [1:0]       kind_i,
  input  stamp_t           stamp_ns_i,
  input  gid_t             group_id_i,
  input  mcfs_cmd_t        cmd_i,
  output mcfs_sts_t        sts_o,
  output logic             valid_o,
  output logic             found_o,
  output gid_t             result_id_o,
  output stamp_t           result_stamp_ns_o,
  output logic             dropped_o,
  output logic             completed_o,
  output logic [1:0]       error_code_o
);

  // Configuration.
  cnt_t             ncam_q;
  logic [TOL_W-1:0] tol_q;

  // Slot ring.
  logic   slot_valid_q [SLOT_COUNT];
  stamp_t slot_stamp_q [SLOT_COUNT];
  gid_t   slot_group_q [SLOT_COUNT];
  cnt_t   slot_cnt_q   [SLOT_COUNT];

  slot_idx_t wp_q;
  gid_t      next_group_q;
  gid_t      last_group_q;
  stamp_t    last_stamp_q;

  // Item under work.
  logic [1:0] kind_q;
  stamp_t     stamp_q;
  gid_t       id_q;
  slot_idx_t  idx_q;
  logic       hit_q;
  stamp_t     lo_q;
  stamp_t     diff_q;

  // Result registers.
  logic       valid_q;
  logic       found_q;
  gid_t       rid_q;
  stamp_t     rstamp_q;
  logic       drop_q;
  logic       done_q;
  logic [1:0] err_q;

  // Current slot, read at the single search/commit index.
  logic   cur_valid;
  stamp_t cur_stamp;
  gid_t   cur_group;
  cnt_t   cur_cnt;

  logic [STAMP_W:0] sub_st;
  logic             s_lt_t;
  stamp_t           diff;
  stamp_t           lo;
  logic             time_ok;
  logic             id_ok;
  logic             match;
  stamp_t           mid;

  logic       res_found;
  gid_t       res_id;
  stamp_t     res_stamp;
  logic       res_drop;
  logic       res_done;
  logic [1:0] res_err;
  logic       wr_open;
  logic       wr_merge;
  logic       wr_inc;
  logic       wr_last;

  assign cur_valid = slot_valid_q[idx_q];
  assign cur_stamp = slot_stamp_q[idx_q];
  assign cur_group = slot_group_q[idx_q];
  assign cur_cnt   = slot_cnt_q[idx_q];

  // Absolute distance between slot and frame stamps, worked out for each probe.
  assign sub_st  = {1'b0, cur_stamp} - {1'b0, stamp_q};
  assign s_lt_t  = sub_st[STAMP_W];
  assign diff    = s_lt_t ? stamp_t'(stamp_q - cur_stamp) : sub_st[STAMP_W-1:0];
  assign lo      = s_lt_t ? cur_stamp : stamp_q;
  assign time_ok = (diff == '0) || (diff < STAMP_W'(tol_q));
  assign id_ok   = (cur_group == id_q);

  always_comb begin
    case (kind_q)
      KIND_FRAME:            match = cur_valid & time_ok;
      KIND_DONE, KIND_QUERY: match = cur_valid & id_ok;
      default:               match = 1'b0;
    endcase
  end

  assign sts_o.match = match;
  assign sts_o.skip  = (kind_q == KIND_NONE);

  // Floor midpoint of the two stamps.
  assign mid = stamp_t'(lo_q + (diff_q >> 1));

  always_comb begin
    res_found = 1'b0;
    res_id    = '0;
    res_stamp = '0;
    res_drop  = 1'b0;
    res_done  = 1'b0;
    res_err   = ERR_NONE;
    wr_open   = 1'b0;
    wr_merge  = 1'b0;
    wr_inc    = 1'b0;
    wr_last   = 1'b0;
    case (kind_q)
      KIND_FRAME: begin
        if (hit_q) begin
          res_found = 1'b1;
          res_id    = cur_group;
          res_stamp = mid;
          wr_merge  = 1'b1;
        end else begin
          // The search index already sits on the slot after the write pointer.
          res_id    = next_group_q;
          res_stamp = stamp_q;
          res_drop  = cur_valid & (cur_cnt != ncam_q);
          wr_open   = 1'b1;
        end
      end
      KIND_DONE: begin
        res_id = id_q;
        if (hit_q) begin
          res_found = 1'b1;
          res_stamp = cur_stamp;
          if ((cur_cnt >= ncam_q) || (cur_cnt >= COUNT_MAX)) begin
            res_err = ERR_OVERFLOW;
          end else begin
            wr_inc = 1'b1;
          end
        end
      end
      KIND_QUERY: begin
        res_id = id_q;
        if (hit_q) begin
          res_found = 1'b1;
          res_stamp = cur_stamp;
          if (cur_cnt == ncam_q) begin
            if ((cur_stamp > last_stamp_q) &&
                ((last_group_q == '0) || (cur_group > last_group_q))) begin
              res_done = 1'b1;
              wr_last  = 1'b1;
            end else begin
              res_err = ERR_ORDER;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncam_q       <= NUM_CAMERAS_RST;
      tol_q        <= TIME_TOL_RST;
      wp_q         <= '0;
      next_group_q <= gid_t'(1);
      last_group_q <= '0;
      last_stamp_q <= '0;
      valid_q      <= 1'b0;
      hit_q        <= 1'b0;
      idx_q        <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_valid_q[i] <= 1'b0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NUM_CAMERAS: ncam_q <= cfg_wdata_i[CNT_W-1:0];
          CFG_TIME_TOL:    tol_q  <= cfg_wdata_i[TOL_W-1:0];
          default: begin
          end
        endcase
      end
      valid_q <= cmd_i.commit;
      if (cmd_i.load) begin
        idx_q <= wp_q;
        hit_q <= 1'b0;
      end
      if (cmd_i.probe) begin
        if (match) begin
          hit_q <= 1'b1;
        end else if (cmd_i.last) begin
          idx_q <= next_slot(wp_q);
        end else begin
          idx_q <= next_slot(idx_q);
        end
      end
      if (cmd_i.commit) begin
        if (wr_open) begin
          wp_q                <= idx_q;
          slot_valid_q[idx_q] <= 1'b1;
          next_group_q        <= gid_t'(next_group_q + 1'b1);
        end
        if (wr_last) begin
          last_group_q <= cur_group;
          last_stamp_q <= cur_stamp;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      stamp_q <= stamp_ns_i;
      id_q    <= group_id_i;
    end
    if (cmd_i.probe && match) begin
      lo_q   <= lo;
      diff_q <= diff;
    end
    if (cmd_i.commit) begin
      found_q  <= res_found;
      rid_q    <= res_id;
      rstamp_q <= res_stamp;
      drop_q   <= res_drop;
      done_q   <= res_done;
      err_q    <= res_err;
      if (wr_open) begin
        slot_stamp_q[idx_q] <= stamp_q;
        slot_group_q[idx_q] <= next_group_q;
        slot_cnt_q[idx_q]   <= '0;
      end
      if (wr_merge) begin
        slot_stamp_q[idx_q] <= mid;
      end
      if (wr_inc) begin
        slot_cnt_q[idx_q] <= cnt_t'(cur_cnt + 1'b1);
      end
    end
  end

  assign valid_o           = valid_q;
  assign found_o           = found_q;
  assign result_id_o       = rid_q;
  assign result_stamp_ns_o = rstamp_q;
  assign dropped_o         = drop_q;
  assign completed_o       = done_q;
  assign error_code_o      = err_q;

endmodule

// ===== src/multi_camera_frame_sync.sv =====
// ----------------------------------------------------------------------------
// Multi-camera frame sync
// Groups camera frames by timestamp in a small slot ring and tracks completion.
// ----------------------------------------------------------------------------
// An item is presented on kind_i, stamp_ns_i and group_id_i and is accepted at
// a rising edge where start is high and busy is low. A new-frame item searches
// the slot ring for a stamp within the tolerance; detection-ended and query
// items search it for a group id. Every item yields exactly one result, shown
// on the result ports for a single cycle and marked by valid_o.
// The search tests one slot per cycle, starting at the write pointer, and stops
// at the first match or at the last slot; the update state then commits the
// result. The result strobe is registered from the update state, and busy is
// low again in the strobe cycle, so a new item may be accepted in that cycle;
// no item is taken while busy. An unused item kind skips the slot tests.
// The configuration port writes num_cameras (index 0) or time_tolerance_ns
// (index 1); it should be used only while the block is idle.
// Reset empties all slots, clears the write pointer and the record of the last
// completed group, sets the next group id to one and restores the register
// defaults. The receiver cannot hold a result off: it must take it on the cycle
// valid_o is high.
// ----------------------------------------------------------------------------
module multi_camera_frame_sync import mcfs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       kind_i,
  input  stamp_t           stamp_ns_i,
  input  gid_t             group_id_i,
  output logic             valid_o,
  output logic             found_o,
  output gid_t             result_id_o,
  output stamp_t           result_stamp_ns_o,
  output logic             dropped_o,
  output logic             completed_o,
  output logic [1:0]       error_code_o
);

  mcfs_cmd_t cmd;
  mcfs_sts_t sts;

  // The controller owns sequencing only; all slot state lives in the datapath.
  mcfs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  mcfs_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .kind_i            (kind_i),
    .stamp_ns_i        (stamp_ns_i),
    .group_id_i        (group_id_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .valid_o           (valid_o),
    .found_o           (found_o),
    .result_id_o       (result_id_o),
    .result_stamp_ns_o (result_stamp_ns_o),
    .dropped_o         (dropped_o),
    .completed_o       (completed_o),
    .error_code_o      (error_code_o)
  );

`ifndef NO_ASSERTIONS
  // The result is only shown once the block has returned to idle.
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result strobe while busy");

  // An accepted item keeps the block busy on the following cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // Each item gives a single-cycle strobe, never two in a row.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held for more than one cycle");

  // A drop only happens when a new slot was opened, never on a join.
  a_drop_no_join: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && dropped_o) |-> !found_o)
    else $error("drop reported on a matched frame");

  // A completed group was found and carries no error.
  a_complete_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && completed_o) |-> (found_o && (error_code_o == ERR_NONE)))
    else $error("completion reported with error or without a match");
`endif

endmodule

// ===== verif/mcfs_checker.sv =====
// ----------------------------------------------------------------------------
// Frame sync checker
// Follows the item and result ports of the multi-camera frame sync block,
// keeps its own copy of the slot ring and registers, and compares every
// result with the outcome worked out when its item was accepted.
// ----------------------------------------------------------------------------
module mcfs_checker import mcfs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic [1:0]       kind_i,
  input  stamp_t           stamp_ns_i,
  input  gid_t             group_id_i,
  input  logic             valid_i,
  input  logic             found_i,
  input  gid_t             result_id_i,
  input  stamp_t           result_stamp_ns_i,
  input  logic             dropped_i,
  input  logic             completed_i,
  input  logic [1:0]       error_code_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       found;
    gid_t       id;
    stamp_t     stamp;
    logic       dropped;
    logic       completed;
    logic [1:0] err;
  } group_result_t;

  group_result_t outcomes_due[$];
  int unsigned   mismatches;

  // Slot ring and bookkeeping.
  logic        held       [SLOT_COUNT];
  stamp_t      held_stamp [SLOT_COUNT];
  gid_t        held_gid   [SLOT_COUNT];
  cnt_t        done_cnt   [SLOT_COUNT];
  int unsigned head;
  gid_t        gid_next;
  gid_t        last_gid;
  stamp_t      last_stamp;

  // Register copies.
  cnt_t             cameras;
  logic [TOL_W-1:0] tolerance;

  function automatic logic stamps_close(stamp_t a, stamp_t b);
    stamp_t gap;
    gap = (a > b) ? a - b : b - a;
    return (gap == '0) || (gap < stamp_t'(tolerance));
  endfunction

  function automatic int slot_by_stamp(stamp_t t);
    int p;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      p = (head + i) % SLOT_COUNT;
      if (held[p] && stamps_close(held_stamp[p], t)) return p;
    end
    return -1;
  endfunction

  function automatic int slot_by_gid(gid_t id);
    int p;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      p = (head + i) % SLOT_COUNT;
      if (held[p] && held_gid[p] == id) return p;
    end
    return -1;
  endfunction

  // Applies one item to the ring and returns the result it must produce.
  function automatic group_result_t group_outcome(logic [1:0] kind, stamp_t t, gid_t id);
    group_result_t r;
    int            p;
    stamp_t        lo;
    stamp_t        hi;
    r = '0;
    case (kind)
      KIND_FRAME: begin
        p = slot_by_stamp(t);
        if (p >= 0) begin
          if (held_stamp[p] != t) begin
            lo = (held_stamp[p] < t) ? held_stamp[p] : t;
            hi = (held_stamp[p] < t) ? t : held_stamp[p];
            held_stamp[p] = lo + ((hi - lo) >> 1);
          end
          r.found = 1'b1;
          r.id    = held_gid[p];
          r.stamp = held_stamp[p];
        end else begin
          head = (head + 1) % SLOT_COUNT;
          r.dropped        = held[head] && (done_cnt[head] != cameras);
          held[head]       = 1'b1;
          held_stamp[head] = t;
          held_gid[head]   = gid_next;
          done_cnt[head]   = '0;
          r.id     = gid_next;
          r.stamp  = t;
          gid_next = gid_next + 1'b1;
        end
      end
      KIND_DONE: begin
        r.id = id;
        p = slot_by_gid(id);
        if (p >= 0) begin
          r.found = 1'b1;
          r.stamp = held_stamp[p];
          if (done_cnt[p] >= cameras || done_cnt[p] >= COUNT_MAX) r.err = ERR_OVERFLOW;
          else done_cnt[p] = done_cnt[p] + 1'b1;
        end
      end
      KIND_QUERY: begin
        r.id = id;
        p = slot_by_gid(id);
        if (p >= 0) begin
          r.found = 1'b1;
          r.stamp = held_stamp[p];
          if (done_cnt[p] == cameras) begin
            if (held_stamp[p] > last_stamp && (last_gid == '0 || held_gid[p] > last_gid)) begin
              last_gid    = held_gid[p];
              last_stamp  = held_stamp[p];
              r.completed = 1'b1;
            end else begin
              r.err = ERR_ORDER;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : observe
    group_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        held[i]       = 1'b0;
        held_stamp[i] = '0;
        held_gid[i]   = '0;
        done_cnt[i]   = '0;
      end
      head       = 0;
      gid_next   = 1;
      last_gid   = '0;
      last_stamp = '0;
      cameras    = NUM_CAMERAS_RST;
      tolerance  = TIME_TOL_RST;
      mismatches = 0;
      outcomes_due.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // The result leaving at this edge belongs to an earlier item, so it is
      // matched before any item accepted at the same edge is queued.
      if (valid_i) begin
        if (outcomes_due.size() == 0) begin
          $error("result with id 0x%0h arrived with nothing outstanding", result_id_i);
          mismatches++;
        end else begin
          want = outcomes_due.pop_front();
          check_field("found", want.found, found_i);
          check_field("result_id", want.id, result_id_i);
          check_field("result_stamp_ns", want.stamp, result_stamp_ns_i);
          check_field("dropped", want.dropped, dropped_i);
          check_field("completed", want.completed, completed_i);
          check_field("error_code", want.err, error_code_i);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_NUM_CAMERAS) cameras = cfg_wdata_i[CNT_W-1:0];
        else tolerance = cfg_wdata_i[TOL_W-1:0];
      end
      if (start_i && !busy_i)
        outcomes_due.push_back(group_outcome(kind_i, stamp_ns_i, group_id_i));
      fail_count_o <= mismatches;
      pending_o    <= outcomes_due.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Frame sync testbench
// Drives frame, detection-ended and query items into the multi-camera frame
// sync block under a series of register settings and lets the checker compare
// every result; the run ends with a single verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import mcfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_PHASES    = 10;
  localparam int PHASE_ITEMS = 165;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic             start;
  logic             busy;
  logic [1:0]       kind_i;
  stamp_t           stamp_ns_i;
  gid_t             group_id_i;
  logic             valid_o;
  logic             found_o;
  gid_t             result_id_o;
  stamp_t           result_stamp_ns_o;
  logic             dropped_o;
  logic             completed_o;
  logic [1:0]       error_code_o;

  int unsigned fail_count;
  int unsigned pending;

  // Register settings per phase. The list walks through both ends of each
  // register: a camera count of zero and fifteen (outside the nominal range,
  // used as written), and tolerances of zero and the full 32-bit value.
  cnt_t             phase_cams [N_PHASES] = '{4'd2, 4'd1, 4'd8, 4'd0, 4'd15,
                                              4'd3, 4'd4, 4'd5, 4'd1, 4'd2};
  logic [TOL_W-1:0] phase_tol  [N_PHASES] = '{32'd5000000, 32'd1000, 32'd0, 32'd300,
                                              32'hFFFF_FFFF, 32'd5000000, 32'd1,
                                              32'd12345, 32'hFFFF_FFFF, 32'd0};

  // Stimulus bookkeeping. The settings in force are mirrored here so that the
  // generated frames can be placed inside or outside the grouping window.
  int unsigned      items_sent     = 0;
  int unsigned      directed_items = 0;
  int unsigned      results_seen   = 0;
  logic             quiet          = 1'b0;
  logic [63:0]      timeline       = 64'd2_000_000_000_000;
  cnt_t             cams_now       = NUM_CAMERAS_RST;
  logic [TOL_W-1:0] tol_now        = TIME_TOL_RST;

  // Group ids handed out by the block for recent frames, kept in a ring of four. They
  // let the detection-ended and query items aim at groups that are still
  // held in the ring.
  gid_t       live_ids [4] = '{default: '0};
  int         live_wr      = 0;
  logic [1:0] kinds_in_flight[$];

  multi_camera_frame_sync dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .start             (start),
    .busy              (busy),
    .kind_i            (kind_i),
    .stamp_ns_i        (stamp_ns_i),
    .group_id_i        (group_id_i),
    .valid_o           (valid_o),
    .found_o           (found_o),
    .result_id_o       (result_id_o),
    .result_stamp_ns_o (result_stamp_ns_o),
    .dropped_o         (dropped_o),
    .completed_o       (completed_o),
    .error_code_o      (error_code_o)
  );

  mcfs_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .start_i           (start),
    .busy_i            (busy),
    .kind_i            (kind_i),
    .stamp_ns_i        (stamp_ns_i),
    .group_id_i        (group_id_i),
    .valid_i           (valid_o),
    .found_i           (found_o),
    .result_id_i       (result_id_o),
    .result_stamp_ns_i (result_stamp_ns_o),
    .dropped_i         (dropped_o),
    .completed_i       (completed_o),
    .error_code_i      (error_code_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Results arrive in item order, so the kind of each accepted item is
  // queued here and the id of every frame result is kept for later items.
  // Only this block touches the queue; the counters it shares with the
  // stimulus are updated with nonblocking assignments.
  always @(posedge clk_i) begin : result_watch
    logic [1:0] k;
    if (valid_o) begin
      results_seen <= results_seen + 1;
      if (kinds_in_flight.size() != 0) begin
        k = kinds_in_flight.pop_front();
        if (k == KIND_FRAME) begin
          live_ids[live_wr] <= result_id_o;
          live_wr           <= (live_wr + 1) % 4;
        end
      end
    end
    if (start && !busy) kinds_in_flight.push_back(kind_i);
  end

  function automatic stamp_t rand_stamp();
    return stamp_t'({$urandom, $urandom});
  endfunction

  // Outside the final phase the sender sometimes holds back for a burst of
  // cycles, parking random values on the unused fields meanwhile.
  task automatic pause_random();
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 12);
      start      <= 1'b0;
      kind_i     <= 2'($urandom);
      stamp_ns_i <= rand_stamp();
      group_id_i <= gid_t'($urandom);
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Presents one item and returns at the edge that accepts it. Start is left
  // high, so a following item goes out without a gap unless a pause comes first.
  task automatic issue(input logic [1:0] kind, input stamp_t t, input gid_t id);
    pause_random();
    start      <= 1'b1;
    kind_i     <= kind;
    stamp_ns_i <= t;
    group_id_i <= id;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
  endtask

  // Stops sending and waits until every accepted item has had its result.
  task automatic settle();
    start <= 1'b0;
    while (results_seen != items_sent) @(posedge clk_i);
  endtask

  // One camera group as the system would see it: a few frames inside the
  // tolerance window, detection-ended events for each camera and a query.
  // Now and then one event too many (counter overflow), one too few
  // (incomplete group, later overwritten as a drop), an early query, or a
  // repeated query (order violation).
  task automatic run_group();
    int   frames;
    int   dones;
    int   pick;
    gid_t gid;
    // The step keeps the new frames clear of the previous group, whose stamp
    // may have moved up by half the tolerance when frames were merged.
    timeline = timeline + 2 * 64'(tol_now) + $urandom_range(1, 100000);
    frames   = $urandom_range(1, 4);
    repeat (frames)
      issue(KIND_FRAME, stamp_t'(timeline + $urandom_range(0, tol_now >> 1)),
            gid_t'($urandom));
    settle();
    gid  = live_ids[(live_wr + 3) % 4];
    pick = $urandom_range(0, 9);
    if (pick < 7) dones = cams_now;
    else if (pick < 9) dones = cams_now + 1;
    else dones = (cams_now != 0) ? cams_now - 1 : 0;
    for (int d = 0; d < dones; d++) begin
      issue(KIND_DONE, rand_stamp(), gid);
      if ($urandom_range(0, 5) == 0) issue(KIND_QUERY, rand_stamp(), gid);
    end
    issue(KIND_QUERY, rand_stamp(), gid);
    if ($urandom_range(0, 4) == 0) issue(KIND_QUERY, rand_stamp(), gid);
  endtask

  // Broken traffic: stray frames far off or slightly in the past, events for recent
  // and unknown ids, queries for unknown ids, and the unused kind. Queries here never
  // aim at a held group, so a stray stamp is never recorded as the last completion.
  task automatic run_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: issue(KIND_FRAME, rand_stamp(), gid_t'($urandom));
        1: issue(KIND_FRAME,
                 stamp_t'(timeline - 64'(tol_now) * $urandom_range(0, 3)
                          - $urandom_range(0, 1000)),
                 gid_t'($urandom));
        2: issue(KIND_DONE, rand_stamp(), live_ids[$urandom_range(0, 3)]);
        3: issue(KIND_QUERY, rand_stamp(), gid_t'($urandom));
        4: issue(KIND_NONE, rand_stamp(), gid_t'($urandom));
        default: issue(KIND_DONE, rand_stamp(), gid_t'($urandom));
      endcase
    end
  endtask

  // Directed opening under the reset settings (two cameras, 5 ms window).
  // Ids follow from reset: the first new group is one and so on.
  task automatic directed_checks();
    issue(KIND_NONE, '1, '1);                        // unused kind, all fields high
    issue(KIND_FRAME, stamp_t'(1000), '0);           // opens group 1
    issue(KIND_FRAME, stamp_t'(5000999), '0);        // just inside: merge to midpoint
    issue(KIND_FRAME, stamp_t'(7500999), '0);        // exactly one window off: group 2
    issue(KIND_DONE, '0, gid_t'(1));
    issue(KIND_QUERY, '0, gid_t'(1));                // found but not yet complete
    issue(KIND_DONE, '0, gid_t'(1));
    issue(KIND_DONE, '0, gid_t'(1));                 // counter overflow
    issue(KIND_QUERY, '0, gid_t'(1));                // completes
    issue(KIND_QUERY, '0, gid_t'(1));                // same group again: order violation
    issue(KIND_DONE, '1, gid_t'(999));               // unknown id
    issue(KIND_QUERY, '0, '1);                       // unknown id, all bits set
    issue(KIND_QUERY, '0, '0);                       // id zero is never held
    issue(KIND_FRAME, '1, '1);                       // largest stamp: group 3
    issue(KIND_FRAME, stamp_t'(64'd100_000_000), '0); // group 4 over a complete group
    issue(KIND_FRAME, stamp_t'(64'd1_000_000_000_000), '0); // group 5, drops group 2
    issue(KIND_DONE, '0, gid_t'(5));
    issue(KIND_DONE, '0, gid_t'(5));
    issue(KIND_QUERY, '0, gid_t'(5));                // later group completes in order
    issue(KIND_FRAME, stamp_t'('1) - stamp_t'(4999999), '0); // merge at the top end
    issue(KIND_QUERY, '0, gid_t'(3));
    directed_items = items_sent;
  endtask

  initial begin : stimulus
    int unsigned goal;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_NUM_CAMERAS;
    cfg_wdata_i <= '0;
    kind_i      <= KIND_NONE;
    stamp_ns_i  <= '0;
    group_id_i  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_checks();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // Registers change only with the block idle: every result is back and
      // a few spare cycles have passed.
      settle();
      repeat (4) @(posedge clk_i);
      cams_now = phase_cams[ph];
      tol_now  = phase_tol[ph];
      // The upper bits of the camera count write are random; only the low
      // four bits are kept by the block.
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_NUM_CAMERAS;
      cfg_wdata_i <= ($urandom & 32'hFFFF_FFF0) | CFG_W'(cams_now);
      @(posedge clk_i);
      cfg_idx_i   <= CFG_TIME_TOL;
      cfg_wdata_i <= tol_now;
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      // The final phase runs without idling, with stamps moved high up the
      // range while still increasing.
      if (ph == N_PHASES - 1) begin
        quiet    = 1'b1;
        timeline = 64'h4000_0000_0000_0000 | 64'($urandom);
      end
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        if ($urandom_range(0, 4) == 0) run_noise();
        else run_group();
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (pending != 0) $error("%0d results never arrived", pending);
    $display("Sent %0d items (%0d directed) under %0d register settings, zero to fifteen",
             items_sent, directed_items, N_PHASES);
    $display("cameras and windows from none to full width; %0d results compared.",
             results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("multi_camera_frame_sync test passed");
    end else begin
      $display("multi_camera_frame_sync test failed");
    end
    $finish;
  end

  // Generous ceiling: a correct run needs well under a tenth of this.
  initial begin : watchdog
    #5ms;
    $display("multi_camera_frame_sync test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
src/mcfs_pkg.sv
src/mcfs_ctrl.sv
src/mcfs_dp.sv
src/multi_camera_frame_sync.sv
verif/mcfs_checker.sv
verif/tb_top.sv
